// ===== rtl/core/gdn_pkg.sv =====
// Shared types, constants and calendar tables for the date-to-day-number pipeline.
package gdn_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned PROD_W   = 27;
    localparam int unsigned Q100_W   = 8;
    localparam int unsigned YDAY_W   = 9;
    localparam int unsigned SERIAL_W = 23;
    localparam int unsigned OUT_SERIAL_W = 22;

    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
    localparam logic [12:0]        RECIP_100  = 13'd5243;   // ceil(2^19 / 100)
    localparam int unsigned        RECIP_SHIFT = 19;
    localparam logic [YEAR_W-1:0]  CENTURY    = 14'd100;
    localparam logic [YEAR_W-1:0]  CENTURY_LAST = 14'd99;
    localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 23'd365;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

    localparam logic [1:0] ORD_EARLIER = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_LATER   = 2'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]  p;       // year - 1, zero for year 0
        logic [PROD_W-1:0]  prod;    // p * RECIP_100
        logic               yzero;
        logic               ybig;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } div_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  p;
        logic [Q100_W-1:0]  q100;
        logic               leap;
        logic               ok;
        logic [YDAY_W-1:0]  yday;
    } cal_t;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [YDAY_W-1:0]   yday;
        logic                leap;
        logic                ok;
    } ser_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
                4'd2:                                      r = 5'd28;
                default:                                   r = 5'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [YDAY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [YDAY_W-1:0] r;
        begin
            case (m)
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // 2^3 == 1 mod 7: fold octal digits
    function automatic logic [2:0] mod7(input logic [OUT_SERIAL_W-1:0] v);
        logic [23:0] x;
        logic [5:0]  s;
        logic [3:0]  t;
        logic [3:0]  u;
        begin
            x = {2'b00, v};
            s = 6'd0;
            for (int i = 0; i < 8; i++)
            begin
                s = s + {3'b000, x[3*i +: 3]};
            end
            t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
            u = {3'b000, t[3]} + {1'b0, t[2:0]};
            return (u[2:0] == 3'd7) ? 3'd0 : u[2:0];
        end
    endfunction

endpackage

// ===== rtl/core/gdn_div_stage.sv =====
// Stage 1: year offset and reciprocal product for the divide by 100.
module gdn_div_stage
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [gdn_pkg::YEAR_W-1:0]   year,
    input  logic [gdn_pkg::MONTH_W-1:0]  month,
    input  logic [gdn_pkg::DAY_W-1:0]    day,
    output gdn_pkg::div_t                q
);

    gdn_pkg::div_t s1_reg;
    gdn_pkg::div_t s1_next;
    logic          yzero;

    always_comb
    begin
        yzero         = (year == '0);
        s1_next.yzero = yzero;
        s1_next.ybig  = (year > gdn_pkg::MAX_YEAR);
        s1_next.p     = yzero ? '0 : year - 14'd1;
        s1_next.prod  = gdn_pkg::PROD_W'(s1_next.p) * gdn_pkg::PROD_W'(gdn_pkg::RECIP_100);
        s1_next.month = month;
        s1_next.day   = day;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign q = s1_reg;

endmodule

// ===== rtl/core/gdn_cal_stage.sv =====
// Stage 2: century quotient, leap rule, date check and ordinal day.
module gdn_cal_stage
(
    input  logic          clk,
    input  logic          en,
    input  gdn_pkg::div_t d,
    output gdn_pkg::cal_t q
);

    gdn_pkg::cal_t                s2_reg;
    gdn_pkg::cal_t                s2_next;
    logic [gdn_pkg::Q100_W-1:0]   q100;
    logic [gdn_pkg::YEAR_W-1:0]   rem;
    logic                         cent;
    logic                         leap;
    logic [gdn_pkg::DAY_W-1:0]    len;

    always_comb
    begin
        q100 = d.prod[gdn_pkg::RECIP_SHIFT +: gdn_pkg::Q100_W];
        rem  = d.p - gdn_pkg::YEAR_W'(q100) * gdn_pkg::CENTURY;
        // year % 100 == 0 <=> (year - 1) % 100 == 99
        cent = (rem == gdn_pkg::CENTURY_LAST);
        leap = d.yzero
             | ((d.p[1:0] == 2'b11) & ~cent)
             | (cent & (q100[1:0] == 2'b11));
        len  = ((d.month == gdn_pkg::MONTH_FEB) && leap) ? gdn_pkg::FEB_LEAP_LEN
                                                        : gdn_pkg::month_len(d.month);
        s2_next.p    = d.p;
        s2_next.q100 = q100;
        s2_next.leap = leap;
        s2_next.ok   = ~d.yzero & ~d.ybig
                     & (d.month >= gdn_pkg::MONTH_JAN) & (d.month <= gdn_pkg::MONTH_DEC)
                     & (d.day != '0) & (d.day <= len);
        s2_next.yday = gdn_pkg::days_before_month(d.month) + gdn_pkg::YDAY_W'(d.day)
                     + gdn_pkg::YDAY_W'((d.month > gdn_pkg::MONTH_FEB) && leap);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign q = s2_reg;

endmodule

// ===== rtl/core/gdn_serial_stage.sv =====
// Stage 3: closed-form days before the year plus the ordinal day.
module gdn_serial_stage
(
    input  logic          clk,
    input  logic          en,
    input  gdn_pkg::cal_t d,
    output gdn_pkg::ser_t q
);

    gdn_pkg::ser_t                  s3_reg;
    gdn_pkg::ser_t                  s3_next;
    logic [gdn_pkg::SERIAL_W-1:0]   dby;

    always_comb
    begin
        dby = gdn_pkg::SERIAL_W'(d.p) * gdn_pkg::DAYS_PER_YEAR
            + gdn_pkg::SERIAL_W'(d.p[gdn_pkg::YEAR_W-1:2])
            - gdn_pkg::SERIAL_W'(d.q100)
            + gdn_pkg::SERIAL_W'(d.q100[gdn_pkg::Q100_W-1:2]);
        s3_next.serial = dby + gdn_pkg::SERIAL_W'(d.yday);
        s3_next.yday   = d.yday;
        s3_next.leap   = d.leap;
        s3_next.ok     = d.ok;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    assign q = s3_reg;

endmodule

// ===== rtl/core/gregorian_date_to_day_number.sv =====
// Top level: four-stage date to serial day, weekday and ordering pipeline.
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, year..ref_day          request in
//   out      out_valid/out_ready, date_valid..order    result out
//
// One request per cycle while out_ready allows; out_valid rises once the request clears stages 1 to 4.
// Stage 1 multiply, stage 2 leap/check, stage 3 serial, stage 4 mod 7/compare.
// rst_n clears only the stage valid bits.
// A stage holds when it is full and the one after it holds; bubbles collapse.
module gregorian_date_to_day_number
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [gdn_pkg::YEAR_W-1:0]        year,
    input  logic [gdn_pkg::MONTH_W-1:0]       month,
    input  logic [gdn_pkg::DAY_W-1:0]         day,
    input  logic [gdn_pkg::YEAR_W-1:0]        ref_year,
    input  logic [gdn_pkg::MONTH_W-1:0]       ref_month,
    input  logic [gdn_pkg::DAY_W-1:0]         ref_day,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              date_valid,
    output logic [gdn_pkg::OUT_SERIAL_W-1:0]  serial_day,
    output logic [2:0]                        week_day,
    output logic [gdn_pkg::YDAY_W-1:0]        day_of_year,
    output logic                              leap_year,
    output logic [1:0]                        order
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic [gdn_pkg::MONTH_W-1:0] ref_month_c;

    gdn_pkg::div_t dat_s1, ref_s1;
    gdn_pkg::cal_t dat_s2, ref_s2;
    gdn_pkg::ser_t dat_s3, ref_s3;

    logic                             ok_reg, ok_next;
    logic [gdn_pkg::OUT_SERIAL_W-1:0] serial_reg, serial_next;
    logic [2:0]                       wday_reg, wday_next;
    logic [gdn_pkg::YDAY_W-1:0]       yday_reg, yday_next;
    logic                             leap_reg, leap_next;
    logic [1:0]                       ord_reg, ord_next;

    assign en4      = ~v4_reg | out_ready;
    assign en3      = ~v3_reg | en4;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign in_ready = en1;

    always_comb
    begin
        if (ref_month < gdn_pkg::MONTH_JAN)
        begin
            ref_month_c = gdn_pkg::MONTH_JAN;
        end
        else if (ref_month > gdn_pkg::MONTH_DEC)
        begin
            ref_month_c = gdn_pkg::MONTH_DEC;
        end
        else
        begin
            ref_month_c = ref_month;
        end
    end

    gdn_div_stage u_dat_div (.clk(clk), .en(en1), .year(year), .month(month),
                             .day(day), .q(dat_s1));
    gdn_div_stage u_ref_div (.clk(clk), .en(en1), .year(ref_year), .month(ref_month_c),
                             .day(ref_day), .q(ref_s1));
    gdn_cal_stage u_dat_cal (.clk(clk), .en(en2), .d(dat_s1), .q(dat_s2));
    gdn_cal_stage u_ref_cal (.clk(clk), .en(en2), .d(ref_s1), .q(ref_s2));
    gdn_serial_stage u_dat_ser (.clk(clk), .en(en3), .d(dat_s2), .q(dat_s3));
    gdn_serial_stage u_ref_ser (.clk(clk), .en(en3), .d(ref_s2), .q(ref_s3));

    always_comb
    begin
        ok_next     = dat_s3.ok;
        leap_next   = dat_s3.leap;
        serial_next = '0;
        wday_next   = '0;
        yday_next   = '0;
        ord_next    = gdn_pkg::ORD_EARLIER;
        if (dat_s3.ok)
        begin
            serial_next = dat_s3.serial[gdn_pkg::OUT_SERIAL_W-1:0];
            wday_next   = gdn_pkg::mod7(dat_s3.serial[gdn_pkg::OUT_SERIAL_W-1:0]);
            yday_next   = dat_s3.yday;
            if (dat_s3.serial < ref_s3.serial)
            begin
                ord_next = gdn_pkg::ORD_EARLIER;
            end
            else if (dat_s3.serial == ref_s3.serial)
            begin
                ord_next = gdn_pkg::ORD_EQUAL;
            end
            else
            begin
                ord_next = gdn_pkg::ORD_LATER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            ok_reg     <= ok_next;
            serial_reg <= serial_next;
            wday_reg   <= wday_next;
            yday_reg   <= yday_next;
            leap_reg   <= leap_next;
            ord_reg    <= ord_next;
        end
    end

    assign out_valid   = v4_reg;
    assign date_valid  = ok_reg;
    assign serial_day  = serial_reg;
    assign week_day    = wday_reg;
    assign day_of_year = yday_reg;
    assign leap_year   = leap_reg;
    assign order       = ord_reg;

endmodule

// ===== rtl/core/gdn_checker.sv =====
// Port-level checks for the date pipeline, bound to the top level.
module gdn_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              date_valid,
    input  logic [gdn_pkg::OUT_SERIAL_W-1:0]  serial_day,
    input  logic [2:0]                        week_day,
    input  logic [gdn_pkg::YDAY_W-1:0]        day_of_year,
    input  logic                              leap_year,
    input  logic [1:0]                        order
);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(serial_day) && $stable(order))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !date_valid |->
            serial_day == '0 && week_day == '0 && day_of_year == '0 && order == '0)
        else $error("invalid date with nonzero fields");

    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_valid |->
            week_day <= 3'd6 && order != 2'd3 && day_of_year != '0 && serial_day != '0)
        else $error("valid date with out-of-range fields");

    a_yday_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_valid && !leap_year |-> day_of_year <= 9'd365)
        else $error("day of year beyond common year length");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind gregorian_date_to_day_number gdn_checker u_gdn_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .date_valid(date_valid),
    .serial_day(serial_day),
    .week_day(week_day),
    .day_of_year(day_of_year),
    .leap_year(leap_year),
    .order(order)
);
